// ===== rtl/core/i2cram_pkg.sv =====
package i2cram_pkg;

  // defaults for the top-level parameter, the recovery pulse limit and the register reset
  localparam int unsigned CountBitsDef   = 8;
  localparam int unsigned RecoveryPulses = 9;
  localparam logic [15:0] HalfBitReset   = 16'd672;

  // command codes carried in the input tuser
  localparam logic [1:0] KindWrite   = 2'd0;
  localparam logic [1:0] KindRead    = 2'd1;
  localparam logic [1:0] KindRecover = 2'd2;
  localparam logic [1:0] KindUnused  = 2'd3;

  // one input beat: one bus tick
  typedef struct packed {
    logic       start_req;
    logic [1:0] kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] count;
    logic [7:0] wr_data;
    logic       sda_in;
  } in_fields_t;

  // one output beat: pin levels and status for that tick
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       wr_take;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic       nack_error;
  } out_fields_t;

endpackage

// ===== rtl/core/i2c_register_access_master.sv =====
// I2C register-access master. Every input beat is one tick of the bus master: it may carry
// a command (register write, register read or bus recovery, taken only while idle) and always
// carries the sampled SDA level. Every input beat yields exactly one output beat with the SCL
// and SDA drive levels for that tick, busy, the wr_take and rd_valid strobes with read data,
// and done with the NACK flag. One beat is taken per cycle; its result appears in the output
// register in the next cycle, and a new beat is taken while that result waits as long as the
// sink takes it in the same cycle. The figure is set by the combinational step of the bus
// sequencer. half_bit_cycles (cfg_wdata_i, reset 672, zero acts as one) counts input beats per
// half-bit segment; write it only while no command is running.
module i2c_register_access_master #(
  parameter int unsigned CountBits = i2cram_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] start_req, [7:1] dev_addr, [15:8] reg_addr, [23:16] count,
  // [31:24] wr_data, [32] sda_in, [39:33] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] scl_low, [1] sda_low, [2] busy_res, [3] wr_take, [4] rd_valid,
  // [12:5] rd_data, [13] done_res, [14] nack_error, [15] zero
  output logic [15:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import i2cram_pkg::*;

  logic        accept;
  logic [15:0] half_bit_q;
  logic [15:0] limit;
  in_fields_t  cmd;
  out_fields_t res;
  out_fields_t out_q;
  logic        out_valid_q, out_valid_d;

  // take a beat whenever the output register is free or being emptied
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // unpack the input beat
  assign cmd.start_req = s_axis_tdata_i[0];
  assign cmd.kind      = s_axis_tuser_i;
  assign cmd.dev_addr  = s_axis_tdata_i[7:1];
  assign cmd.reg_addr  = s_axis_tdata_i[15:8];
  assign cmd.count     = s_axis_tdata_i[23:16];
  assign cmd.wr_data   = s_axis_tdata_i[31:24];
  assign cmd.sda_in    = s_axis_tdata_i[32];

  assign limit = (half_bit_q == '0) ? 16'd1 : half_bit_q;

  i2cram_seq #(
    .CountBits(CountBits)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cmd_i  (cmd),
    .limit_i(limit),
    .res_o  (res)
  );

  // half-bit length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q <= HalfBitReset;
    end else if (cfg_we_i) begin
      half_bit_q <= cfg_wdata_i;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.nack_error, out_q.done_res, out_q.rd_data,
                            out_q.rd_valid, out_q.wr_take, out_q.busy_res,
                            out_q.sda_low, out_q.scl_low};

  // every accepted beat shows up as a result beat in the next cycle
  a_beat_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  // the error flag is only reported with done
  a_nack_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[14] |-> m_axis_tdata_o[13])
    else $error("nack_error without done_res");

  // done and the wr_take and rd_valid strobes only while a command is running
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[13] || m_axis_tdata_o[3] || m_axis_tdata_o[4])
      |-> m_axis_tdata_o[2])
    else $error("status strobe outside a command");

endmodule

// ===== rtl/core/i2cram_seq.sv =====
module i2cram_seq #(
  parameter int unsigned CountBits = i2cram_pkg::CountBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  i2cram_pkg::in_fields_t  cmd_i,
  input  logic [15:0]             limit_i,
  output i2cram_pkg::out_fields_t res_o
);
  import i2cram_pkg::*;

  typedef enum logic [4:0] {
    PhIdle, PhSa, PhSb, PhSc, PhSd,
    PhWlo, PhWhi, PhWal, PhWah, PhWae,
    PhRhi, PhRlo, PhRas, PhRah, PhRae,
    PhEcl, PhEch,
    PhTa, PhTb, PhTc, PhTd
  } phase_e;

  typedef enum logic [2:0] {
    StAddrW, StReg, StData, StAddrR, StRead
  } stage_e;

  phase_e               phase_q, phase_d;
  stage_e               stage_q, stage_d;
  logic [15:0]          wait_q, wait_d;
  logic [15:0]          wait_inc;
  logic [3:0]           bit_q, bit_d;
  logic [7:0]           shift_q, shift_d;
  logic [CountBits-1:0] left_q, left_d;
  logic [3:0]           pulse_q, pulse_d;
  logic                 err_q, err_d;
  logic [1:0]           kind_q, kind_d;
  logic [6:0]           dev_q, dev_d;
  logic [7:0]           reg_q, reg_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  out_fields_t          res;

  // one tick of the bus sequencer
  always_comb begin
    phase_d  = phase_q;
    stage_d  = stage_q;
    wait_d   = wait_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    left_d   = left_q;
    pulse_d  = pulse_q;
    err_d    = err_q;
    kind_d   = kind_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    wait_inc = wait_q + 16'd1;
    res      = '0;

    if (step_i) begin
      // new command, only from idle
      if (phase_q == PhIdle && cmd_i.start_req && cmd_i.kind != KindUnused) begin
        kind_d  = cmd_i.kind;
        dev_d   = cmd_i.dev_addr;
        reg_d   = cmd_i.reg_addr;
        left_d  = CountBits'(cmd_i.count);
        err_d   = 1'b0;
        pulse_d = '0;
        wait_d  = '0;
        stage_d = StAddrW;
        sda_d   = 1'b1;
        if (cmd_i.kind == KindRecover) begin
          scl_d   = 1'b0;
          phase_d = PhEcl;
        end else begin
          phase_d = PhSa;
        end
      end

      // pins show the levels held during this tick
      res.scl_low = ~scl_d;
      res.sda_low = ~sda_d;

      if (phase_d != PhIdle) begin
        res.busy_res = 1'b1;
        wait_inc     = wait_d + 16'd1;
        if (wait_inc >= limit_i) begin
          wait_d = '0;
          // end of the half-bit segment
          unique case (phase_d)
            PhSa: begin phase_d = PhSb; scl_d = 1'b1; end
            PhSb: begin phase_d = PhSc; sda_d = 1'b0; end
            PhSc: begin phase_d = PhSd; scl_d = 1'b0; end
            PhSd: begin
              shift_d = {dev_d, (stage_d == StAddrR)};
              bit_d   = 4'd8;
              phase_d = PhWlo;
              scl_d   = 1'b0;
              sda_d   = dev_d[6];
            end
            PhWlo: begin phase_d = PhWhi; scl_d = 1'b1; end
            PhWhi: begin
              shift_d = {shift_d[6:0], 1'b0};
              bit_d   = bit_d - 4'd1;
              scl_d   = 1'b0;
              if (bit_d != 4'd0) begin
                phase_d = PhWlo;
                sda_d   = shift_d[7];
              end else begin
                phase_d = PhWal;
                sda_d   = 1'b1;
              end
            end
            PhWal: begin phase_d = PhWah; scl_d = 1'b1; end
            PhWah: begin
              if (cmd_i.sda_in) err_d = 1'b1;
              phase_d = PhWae;
              scl_d   = 1'b0;
            end
            PhWae: begin
              if (stage_d == StAddrW) begin
                stage_d = StReg;
                shift_d = reg_d;
                bit_d   = 4'd8;
                phase_d = PhWlo;
                scl_d   = 1'b0;
                sda_d   = reg_d[7];
              end else if (stage_d == StReg && kind_d == KindRead) begin
                // repeated start then address+R
                stage_d = StAddrR;
                phase_d = PhSa;
                sda_d   = 1'b1;
              end else if (stage_d == StAddrR) begin
                if (left_d != '0) begin
                  stage_d = StRead;
                  shift_d = '0;
                  bit_d   = 4'd8;
                  phase_d = PhRhi;
                  scl_d   = 1'b1;
                  sda_d   = 1'b1;
                end else begin
                  phase_d = PhTa;
                  scl_d   = 1'b0;
                end
              end else if (left_d != '0) begin
                // next write byte taken from this beat
                left_d      = left_d - CountBits'(1);
                stage_d     = StData;
                shift_d     = cmd_i.wr_data;
                bit_d       = 4'd8;
                phase_d     = PhWlo;
                scl_d       = 1'b0;
                sda_d       = cmd_i.wr_data[7];
                res.wr_take = 1'b1;
              end else begin
                phase_d = PhTa;
                scl_d   = 1'b0;
              end
            end
            PhRhi: begin
              shift_d = {shift_d[6:0], cmd_i.sda_in};
              bit_d   = bit_d - 4'd1;
              if (bit_d == 4'd0) begin
                res.rd_valid = 1'b1;
                res.rd_data  = shift_d;
              end
              phase_d = PhRlo;
              scl_d   = 1'b0;
            end
            PhRlo: begin
              if (bit_d != 4'd0) begin
                phase_d = PhRhi;
                scl_d   = 1'b1;
                sda_d   = 1'b1;
              end else begin
                // ACK all but the last byte
                phase_d = PhRas;
                sda_d   = ~(left_d > CountBits'(1));
              end
            end
            PhRas: begin phase_d = PhRah; scl_d = 1'b1; end
            PhRah: begin phase_d = PhRae; scl_d = 1'b0; sda_d = 1'b1; end
            PhRae: begin
              if (left_d != '0) left_d = left_d - CountBits'(1);
              if (left_d != '0) begin
                shift_d = '0;
                bit_d   = 4'd8;
                phase_d = PhRhi;
                scl_d   = 1'b1;
                sda_d   = 1'b1;
              end else begin
                phase_d = PhTa;
                scl_d   = 1'b0;
              end
            end
            PhEcl: begin phase_d = PhEch; scl_d = 1'b1; end
            PhEch: begin
              pulse_d = pulse_d + 4'd1;
              if (cmd_i.sda_in || pulse_d >= 4'(RecoveryPulses)) begin
                phase_d = PhTa;
                scl_d   = 1'b0;
              end else begin
                phase_d = PhEcl;
                scl_d   = 1'b0;
              end
            end
            PhTa: begin phase_d = PhTb; sda_d = 1'b0; end
            PhTb: begin phase_d = PhTc; scl_d = 1'b1; end
            PhTc: begin phase_d = PhTd; sda_d = 1'b1; end
            PhTd: begin
              res.done_res   = 1'b1;
              res.nack_error = err_d;
              phase_d        = PhIdle;
            end
            default: phase_d = PhIdle;
          endcase
        end else begin
          wait_d = wait_inc;
        end
      end
    end
  end

  assign res_o = res;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      stage_q <= StAddrW;
      wait_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      pulse_q <= '0;
      err_q   <= 1'b0;
      kind_q  <= '0;
      dev_q   <= '0;
      reg_q   <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      wait_q  <= wait_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      pulse_q <= pulse_d;
      err_q   <= err_d;
      kind_q  <= kind_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule
